// ===== src/qden_pkg.sv =====
// Shared types, constants and Eisenstein-integer arithmetic for the discriminant norm filter.
package qden_pkg;

	localparam int PW          = 36;
	localparam int DW          = 48;
	localparam int CW          = 5;
	localparam int BW          = 63;
	localparam int NW          = 64;
	localparam int COEFF_BOUND = 15;
	localparam int LAT         = 9;

	typedef logic signed [CW-1:0] coef_t;

	typedef struct packed {
		logic signed [PW-1:0] re;
		logic signed [PW-1:0] om;
	} eis_t;

	typedef struct packed {
		logic signed [DW-1:0] re;
		logic signed [DW-1:0] om;
	} eisw_t;

	typedef struct packed {
		logic vld;
		logic box;
	} ctl_t;

	function automatic eis_t to_eis(coef_t r, coef_t o);
		eis_t x;
		x.re = PW'(r);
		x.om = PW'(o);
		return x;
	endfunction

	function automatic logic in_box(coef_t v);
		return (int'(v) >= -COEFF_BOUND) && (int'(v) <= COEFF_BOUND);
	endfunction

	function automatic eis_t emul(eis_t x, eis_t y);
		logic signed [2*PW-1:0] rr, oo, ro, orp;
		eis_t z;
		rr = x.re * y.re;
		oo = x.om * y.om;
		ro = x.re * y.om;
		orp = x.om * y.re;
		z.re = PW'(rr - oo);
		z.om = PW'(ro + orp - oo);
		return z;
	endfunction

	function automatic eisw_t emul_w(eis_t x, eis_t y);
		logic signed [2*PW-1:0] rr, oo, ro, orp;
		eisw_t z;
		rr = x.re * y.re;
		oo = x.om * y.om;
		ro = x.re * y.om;
		orp = x.om * y.re;
		z.re = DW'(rr - oo);
		z.om = DW'(ro + orp - oo);
		return z;
	endfunction

	function automatic eis_t eadd(eis_t x, eis_t y);
		eis_t z;
		z.re = x.re + y.re;
		z.om = x.om + y.om;
		return z;
	endfunction

	function automatic eis_t escale(int k, eis_t x);
		eis_t z;
		z.re = PW'(k * x.re);
		z.om = PW'(k * x.om);
		return z;
	endfunction

	function automatic eisw_t ext(eis_t x);
		eisw_t z;
		z.re = DW'(x.re);
		z.om = DW'(x.om);
		return z;
	endfunction

	function automatic eisw_t eadd_w(eisw_t x, eisw_t y);
		eisw_t z;
		z.re = x.re + y.re;
		z.om = x.om + y.om;
		return z;
	endfunction

endpackage

// ===== src/qden_disc.sv =====
// Six-stage pipeline that computes the quartic discriminant in Z[w].
module qden_disc import qden_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  ctl_t  ctl_in,
	input  eis_t  a,
	input  eis_t  b,
	input  eis_t  c,
	input  eis_t  d,
	input  eis_t  e,
	output ctl_t  ctl_out,
	output eisw_t disc
);

	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;

	eis_t a_s1, b_s1, c_s1, d_s1, e_s1;
	eis_t a2_s1, b2_s1, c2_s1, d2_s1, e2_s1, ab_s1, bc_s1, cd_s1, bd_s1, ad_s1;

	eis_t a3_s2, b3_s2, c3_s2, d3_s2, e3_s2, b4_s2, a2c2_s2, ab2c_s2, a2bd_s2, c4_s2;
	eis_t a2d2_s2, b2d2_s2, abcd_s2, acd2_s2, b2c2_s2;
	eis_t a_s2, b2_s2, c_s2, c2_s2, d2_s2, cd_s2, e_s2, e2_s2;

	eis_t p3_s3, p2_s3, e_s3, e2_s3, e3_s3;
	eis_t m1_s3, m2_s3, m3_s3, m4_s3, m5_s3, m6_s3, m7_s3, m8_s3, m9_s3, m10_s3, m11_s3;

	eis_t  p1_s4, p0_s4, e_s4;
	eisw_t q3_s4, q2_s4;

	eisw_t q1_s5, acc_s5;
	eisw_t disc_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
		end
	end

	always_ff @(posedge clk) begin
		a_s1  <= a;
		b_s1  <= b;
		c_s1  <= c;
		d_s1  <= d;
		e_s1  <= e;
		a2_s1 <= emul(a, a);
		b2_s1 <= emul(b, b);
		c2_s1 <= emul(c, c);
		d2_s1 <= emul(d, d);
		e2_s1 <= emul(e, e);
		ab_s1 <= emul(a, b);
		bc_s1 <= emul(b, c);
		cd_s1 <= emul(c, d);
		bd_s1 <= emul(b, d);
		ad_s1 <= emul(a, d);

		a3_s2   <= emul(a2_s1, a_s1);
		b3_s2   <= emul(b2_s1, b_s1);
		c3_s2   <= emul(c2_s1, c_s1);
		d3_s2   <= emul(d2_s1, d_s1);
		e3_s2   <= emul(e2_s1, e_s1);
		b4_s2   <= emul(b2_s1, b2_s1);
		a2c2_s2 <= emul(a2_s1, c2_s1);
		ab2c_s2 <= emul(ab_s1, bc_s1);
		a2bd_s2 <= emul(ab_s1, ad_s1);
		c4_s2   <= emul(c2_s1, c2_s1);
		a2d2_s2 <= emul(ad_s1, ad_s1);
		b2d2_s2 <= emul(bd_s1, bd_s1);
		abcd_s2 <= emul(ab_s1, cd_s1);
		acd2_s2 <= emul(ad_s1, cd_s1);
		b2c2_s2 <= emul(bc_s1, bc_s1);
		a_s2    <= a_s1;
		b2_s2   <= b2_s1;
		c_s2    <= c_s1;
		c2_s2   <= c2_s1;
		d2_s2   <= d2_s1;
		cd_s2   <= cd_s1;
		e_s2    <= e_s1;
		e2_s2   <= e2_s1;

		p3_s3  <= escale(256, a3_s2);
		p2_s3  <= eadd(eadd(escale(-27, b4_s2), escale(-128, a2c2_s2)),
			eadd(escale(144, ab2c_s2), escale(-192, a2bd_s2)));
		m1_s3  <= emul(a_s2, c4_s2);
		m2_s3  <= emul(b2_s2, c3_s2);
		m3_s3  <= emul(c_s2, a2d2_s2);
		m4_s3  <= emul(a_s2, b2d2_s2);
		m5_s3  <= emul(c_s2, abcd_s2);
		m6_s3  <= emul(b3_s2, cd_s2);
		m7_s3  <= emul(a2d2_s2, d2_s2);
		m8_s3  <= emul(abcd_s2, d2_s2);
		m9_s3  <= emul(b3_s2, d3_s2);
		m10_s3 <= emul(acd2_s2, c2_s2);
		m11_s3 <= emul(b2c2_s2, d2_s2);
		e_s3   <= e_s2;
		e2_s3  <= e2_s2;
		e3_s3  <= e3_s2;

		p1_s4 <= eadd(eadd(eadd(escale(16, m1_s3), escale(-4, m2_s3)),
			eadd(escale(144, m3_s3), escale(-6, m4_s3))),
			eadd(escale(-80, m5_s3), escale(18, m6_s3)));
		p0_s4 <= eadd(eadd(eadd(escale(-27, m7_s3), escale(18, m8_s3)),
			eadd(escale(-4, m9_s3), escale(-4, m10_s3))), m11_s3);
		q3_s4 <= emul_w(p3_s3, e3_s3);
		q2_s4 <= emul_w(p2_s3, e2_s3);
		e_s4  <= e_s3;

		q1_s5  <= emul_w(p1_s4, e_s4);
		acc_s5 <= eadd_w(eadd_w(q3_s4, q2_s4), ext(p0_s4));

		disc_s6 <= eadd_w(acc_s5, q1_s5);
	end

	assign ctl_out = ctl_s6;
	assign disc    = disc_s6;

endmodule

// ===== src/qden_norm.sv =====
// Three-stage norm, saturation and bound compare of the discriminant.
module qden_norm import qden_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  ctl_t          ctl_in,
	input  eisw_t         disc,
	input  logic [BW-1:0] norm_bound,
	output logic          done,
	output logic [NW-1:0] disc_norm,
	output logic          nonsingular,
	output logic          hit
);

	localparam int UW = 44;
	localparam int HW = UW / 2;
	localparam int SW = 2 * UW + 2;

	logic signed [DW+1:0] t_re, t_om;
	logic [DW+1:0]        ua, va;
	logic [UW-1:0]        u, v;
	logic [SW-1:0]        us, vs, sq;

	ctl_t          ctl_s7, ctl_s8, ctl_s9;
	logic [UW-1:0] uhh_s7, uhl_s7, ull_s7, vhh_s7, vhl_s7, vll_s7;
	logic          nz_s7, nz_s8, nz_s9;
	logic          ovf_s8;
	logic [NW-1:0] nl_s8, norm_s9;
	logic          hit_s9;

	always_comb begin
		t_re = ((DW+2)'(disc.re) <<< 1) - (DW+2)'(disc.om);
		t_om = (DW+2)'(disc.om);
		ua   = t_re[DW+1] ? (DW+2)'(-t_re) : (DW+2)'(t_re);
		va   = t_om[DW+1] ? (DW+2)'(-t_om) : (DW+2)'(t_om);
		u    = ua[UW-1:0];
		v    = va[UW-1:0];
		us   = (SW'(uhh_s7) << (2*HW)) + (SW'(uhl_s7) << (HW+1)) + SW'(ull_s7);
		vs   = (SW'(vhh_s7) << (2*HW)) + (SW'(vhl_s7) << (HW+1)) + SW'(vll_s7);
		sq   = us + (vs << 1) + vs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s7 <= '0;
			ctl_s8 <= '0;
			ctl_s9 <= '0;
		end else begin
			ctl_s7 <= ctl_in;
			ctl_s8 <= ctl_s7;
			ctl_s9 <= ctl_s8;
		end
	end

	always_ff @(posedge clk) begin
		uhh_s7 <= u[UW-1:HW] * u[UW-1:HW];
		uhl_s7 <= u[UW-1:HW] * u[HW-1:0];
		ull_s7 <= u[HW-1:0] * u[HW-1:0];
		vhh_s7 <= v[UW-1:HW] * v[UW-1:HW];
		vhl_s7 <= v[UW-1:HW] * v[HW-1:0];
		vll_s7 <= v[HW-1:0] * v[HW-1:0];
		nz_s7  <= (disc.re != '0) || (disc.om != '0);

		ovf_s8 <= |sq[SW-1:NW+2];
		nl_s8  <= sq[NW+1:2];
		nz_s8  <= nz_s7;

		norm_s9 <= ovf_s8 ? '1 : nl_s8;
		nz_s9   <= nz_s8;
		hit_s9  <= ctl_s8.box && nz_s8 && !ovf_s8 && (nl_s8 <= NW'(norm_bound));
	end

	assign done        = ctl_s9.vld;
	assign disc_norm   = norm_s9;
	assign nonsingular = nz_s9;
	assign hit         = hit_s9;

endmodule

// ===== src/quartic_disc_eisenstein_norm_filter.sv =====
// Top level of the quartic discriminant Eisenstein-norm filter.
// One quartic enters per cycle whenever start is high; busy stays low, so the block
// never refuses an item. Each result is shown for one cycle with done high, once its
// item has passed every stage, in the order the items came in: six stages compute the
// discriminant (at most one Eisenstein multiply deep each) and three form the norm,
// clamp it and compare it against norm_bound. The receiver cannot stall the block.
// norm_bound is taken on cfg_valid at any cycle; write it only while no item is in flight.
module quartic_disc_eisenstein_norm_filter import qden_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [CW-1:0] c0_re,
	input  logic [CW-1:0] c0_om,
	input  logic [CW-1:0] c1_re,
	input  logic [CW-1:0] c1_om,
	input  logic [CW-1:0] c2_re,
	input  logic [CW-1:0] c2_om,
	input  logic [CW-1:0] c3_re,
	input  logic [CW-1:0] c3_om,
	input  logic [CW-1:0] c4_re,
	input  logic [CW-1:0] c4_om,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [BW-1:0] norm_bound,
	output logic          done,
	output logic [NW-1:0] disc_norm,
	output logic          nonsingular,
	output logic          hit
);

	logic [BW-1:0] bound_q;
	ctl_t          ctl_in, ctl_mid;
	eisw_t         disc;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			bound_q <= norm_bound;
		end
	end

	always_comb begin
		ctl_in.vld = start && !busy;
		ctl_in.box = in_box(c0_re) && in_box(c0_om) && in_box(c1_re) && in_box(c1_om)
			&& in_box(c2_re) && in_box(c2_om) && in_box(c3_re) && in_box(c3_om)
			&& in_box(c4_re) && in_box(c4_om);
	end

	qden_disc u_disc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_in),
		.a       (to_eis(c4_re, c4_om)),
		.b       (to_eis(c3_re, c3_om)),
		.c       (to_eis(c2_re, c2_om)),
		.d       (to_eis(c1_re, c1_om)),
		.e       (to_eis(c0_re, c0_om)),
		.ctl_out (ctl_mid),
		.disc    (disc)
	);

	qden_norm u_norm (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl_in      (ctl_mid),
		.disc        (disc),
		.norm_bound  (bound_q),
		.done        (done),
		.disc_norm   (disc_norm),
		.nonsingular (nonsingular),
		.hit         (hit)
	);

	a_hit_nz: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> nonsingular)
		else $error("hit without nonzero discriminant");

	a_zero_norm: assert property (@(posedge clk) disable iff (!arst_n)
		done && !nonsingular |-> disc_norm == '0)
		else $error("singular result with nonzero norm");

	a_nz_norm: assert property (@(posedge clk) disable iff (!arst_n)
		done && nonsingular |-> disc_norm != '0)
		else $error("nonsingular result with zero norm");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a matching transfer");

endmodule
